FILE: src/mqtr_pkg.sv
package mqtr_pkg;

  // action codes
  typedef logic [2:0] act_t;
  localparam act_t ACT_PUSH  = 3'd0;
  localparam act_t ACT_PLAY  = 3'd1;
  localparam act_t ACT_PAUSE = 3'd2;
  localparam act_t ACT_STOP  = 3'd3;
  localparam act_t ACT_RESET = 3'd4;
  localparam act_t ACT_POLL  = 3'd5;
  localparam act_t ACT_RATE  = 3'd6;

  // playback state codes
  typedef logic [1:0] play_t;
  localparam play_t PS_STOPPED = 2'd0;
  localparam play_t PS_PLAYING = 2'd1;
  localparam play_t PS_PAUSED  = 2'd2;

  // result status codes
  typedef logic [1:0] res_t;
  localparam res_t RES_NONE  = 2'd0;
  localparam res_t RES_FRAME = 2'd1;
  localparam res_t RES_DROP  = 2'd2;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GNUM = 1'b0;
  localparam cfg_idx_t CFG_GDEN = 1'b1;

  localparam logic [30:0] GNUM_RST = 31'd1;
  localparam logic [30:0] GDEN_RST = 31'd1000000;
  localparam logic [31:0] RATE_ONE = 32'h0001_0000;

  // last step counts of the serial units
  localparam logic [6:0] PUSH_MUL_LAST  = 7'd63;
  localparam logic [6:0] MEDIA_MUL_LAST = 7'd31;
  localparam logic [6:0] DIV_LAST       = 7'd127;

  typedef struct packed {
    logic load;
    logic scale;
    logic divsr;
    logic mstep;
    logic dinit;
    logic dstep;
    logic wr;
    logic drop;
    logic play;
    logic minit;
    logic combine;
    logic sinit;
    logic saddr;
    logic scmp;
    logic latch;
    logic pop;
    logic misc;
    logic emit;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic drop;
    logic playing;
    logic clock_ready;
    logic mul_last;
    logic div_last;
    logic scan_last;
    logic found;
    logic out_free;
  } stat_t;

  // sign and magnitude to saturated signed 64 bits
  function automatic logic [63:0] sat64(input logic neg, input logic [127:0] mag);
    logic [63:0] r;
    if (mag[127:63] != '0) begin
      r = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    end else if (neg) begin
      r = 64'd0 - {1'b0, mag[62:0]};
    end else begin
      r = {1'b0, mag[62:0]};
    end
    return r;
  endfunction

endpackage

FILE: src/mqtr_ram.sv
module mqtr_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                   wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                   rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mqtr_ctrl.sv
module mqtr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mqtr_pkg::stat_t stat,
  output mqtr_pkg::cmd_t  cmd
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_DECODE  = 13'b0000000000010,
    S_SCALE   = 13'b0000000000100,
    S_DIVSR   = 13'b0000000001000,
    S_MUL     = 13'b0000000010000,
    S_DINIT   = 13'b0000000100000,
    S_DIV     = 13'b0000001000000,
    S_WRITE   = 13'b0000010000000,
    S_COMBINE = 13'b0000100000000,
    S_SADDR   = 13'b0001000000000,
    S_SCMP    = 13'b0010000000000,
    S_ENDSCAN = 13'b0100000000000,
    S_FIN     = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.act)
          mqtr_pkg::ACT_PUSH: begin
            if (stat.drop) begin
              cmd.drop = 1'b1;
              state_next = S_FIN;
            end else begin
              state_next = S_SCALE;
            end
          end
          mqtr_pkg::ACT_PLAY: begin
            state_next = S_FIN;
            if (!stat.playing) begin
              cmd.play = 1'b1;
              if (!stat.clock_ready) begin
                cmd.sinit = 1'b1;
                state_next = S_SADDR;
              end
            end
          end
          mqtr_pkg::ACT_POLL: begin
            if (stat.playing && stat.clock_ready) begin
              cmd.minit = 1'b1;
              state_next = S_MUL;
            end else begin
              state_next = S_FIN;
            end
          end
          default: begin
            cmd.misc = 1'b1;
            state_next = S_FIN;
          end
        endcase
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_next = S_DIVSR;
      end
      S_DIVSR: begin
        cmd.divsr = 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mstep = 1'b1;
        if (stat.mul_last) begin
          state_next = (stat.act == mqtr_pkg::ACT_PUSH) ? S_DINIT : S_COMBINE;
        end
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (stat.div_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr = 1'b1;
        state_next = S_FIN;
      end
      S_COMBINE: begin
        cmd.combine = 1'b1;
        cmd.sinit = 1'b1;
        state_next = S_SADDR;
      end
      S_SADDR: begin
        cmd.saddr = 1'b1;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        cmd.scmp = 1'b1;
        state_next = stat.scan_last ? S_ENDSCAN : S_SADDR;
      end
      S_ENDSCAN: begin
        if (stat.act == mqtr_pkg::ACT_PLAY) begin
          cmd.latch = 1'b1;
        end else if (stat.found) begin
          cmd.pop = 1'b1;
        end
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: src/mqtr_dp.sv
module mqtr_dp #(
  parameter int NUM_TRACKS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  mqtr_pkg::cmd_t           cmd,
  output mqtr_pkg::stat_t          stat,
  input  logic [2:0]               action,
  input  logic [2:0]               track_sel,
  input  logic [31:0]              frame_handle,
  input  logic signed [63:0]       pts,
  input  logic [30:0]              tb_num,
  input  logic [30:0]              tb_den,
  input  logic [62:0]              now_us,
  input  logic [31:0]              rate_value,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  mqtr_pkg::cfg_idx_t       cfg_index,
  input  logic [30:0]              cfg_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [2:0]               track_out,
  output logic [31:0]              handle_out,
  output logic signed [63:0]       pts_out,
  output logic [62:0]              send_time_out
);

  localparam int TW = NUM_TRACKS > 1 ? $clog2(NUM_TRACKS) : 1;
  localparam int HW = QUEUE_DEPTH > 1 ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int ND = NUM_TRACKS * QUEUE_DEPTH;
  localparam int AW = ND > 1 ? $clog2(ND) : 1;
  localparam logic [AW-1:0] DEP_A = AW'(QUEUE_DEPTH);
  localparam logic [HW:0] DEP_S = (HW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEP_C = CW'(QUEUE_DEPTH);
  localparam logic [TW-1:0] LAST_T = TW'(NUM_TRACKS - 1);

  // configuration registers
  logic [30:0] gnum, gden;

  // latched item
  mqtr_pkg::act_t act_r;
  logic [TW-1:0]  trk_r;
  logic           trk_oob;
  logic [31:0]    handle_r;
  logic [63:0]    pts_r;
  logic [30:0]    num_r, den_r;
  logic [62:0]    now_r;
  logic [31:0]    rate_r;

  // playback state
  mqtr_pkg::play_t play_state;
  logic            clock_ready;
  logic [62:0]     start_wall;
  logic [63:0]     start_media;
  logic [31:0]     rate_q16;
  logic [63:0]     media;

  // per-track queue pointers
  logic [HW-1:0] qhead  [NUM_TRACKS];
  logic [CW-1:0] qcount [NUM_TRACKS];

  // serial multiply and divide unit
  logic [127:0] acc, mcand;
  logic [63:0]  mplier, rem;
  logic [6:0]   cnt;
  logic [61:0]  scale, divsr;
  logic         neg;

  // scan state
  logic [TW-1:0] scan_t, pick;
  logic          found;
  logic [63:0]   best;
  logic [31:0]   best_handle;

  // pending result
  mqtr_pkg::res_t res_status;
  logic [2:0]     res_track;
  logic [31:0]    res_handle;
  logic [63:0]    res_pts;
  logic [62:0]    res_send;

  // queue selection and addresses
  logic [TW-1:0] qidx;
  logic [HW-1:0] head_sel;
  logic [CW-1:0] count_sel;
  logic [HW:0]   wsum;
  logic [HW-1:0] widx;
  logic [AW-1:0] base, raddr, waddr;
  logic [95:0]   rdata, wdata;
  logic [HW-1:0] head_inc;

  // arithmetic
  logic [30:0]  mul_a, mul_b;
  logic [61:0]  prod;
  logic [63:0]  pts_mag;
  logic [63:0]  delta, delta_mag;
  logic [63:0]  sm_mag;
  logic [127:0] ma, sum_add, sum_ab, sum_ba, sum;
  logic         sum_neg;
  logic [63:0]  r2;
  logic         ge;
  logic [63:0]  conv;
  logic [63:0]  p;
  logic         take;
  logic [6:0]   trk7, pick7;
  logic         out_free;

  assign cfg_ready = 1'b1;

  assign qidx = (cmd.saddr || cmd.scmp) ? scan_t : (cmd.pop ? pick : trk_r);
  assign head_sel = qhead[qidx];
  assign count_sel = qcount[qidx];
  assign wsum = (HW + 1)'(head_sel) + (HW + 1)'(count_sel);
  assign widx = (wsum >= DEP_S) ? HW'(wsum - DEP_S) : wsum[HW-1:0];
  assign base = AW'(qidx) * DEP_A;
  assign raddr = base + AW'(head_sel);
  assign waddr = base + AW'(widx);
  assign head_inc = (head_sel == HW'(QUEUE_DEPTH - 1)) ? '0 : head_sel + 1'b1;

  // shared 31 by 31 multiplier for the scale and the divisor
  assign mul_a = cmd.scale ? num_r : den_r;
  assign mul_b = cmd.scale ? gden : gnum;
  assign prod = 62'(mul_a) * 62'(mul_b);

  assign pts_mag = pts_r[63] ? 64'd0 - pts_r : pts_r;
  assign delta = {1'b0, now_r} - {1'b0, start_wall};
  assign delta_mag = delta[63] ? 64'd0 - delta : delta;
  assign sm_mag = start_media[63] ? 64'd0 - start_media : start_media;

  // signed magnitude sum of start media and scaled elapsed time
  always_comb begin
    ma = {48'd0, sm_mag, 16'd0};
    sum_add = ma + acc;
    sum_ab = ma - acc;
    sum_ba = acc - ma;
    if (start_media[63] == neg) begin
      sum = sum_add;
      sum_neg = neg;
    end else if (ma >= acc) begin
      sum = sum_ab;
      sum_neg = start_media[63];
    end else begin
      sum = sum_ba;
      sum_neg = neg;
    end
  end

  // restoring division step
  assign r2 = {rem[62:0], acc[127]};
  assign ge = r2 >= {2'b00, divsr};

  assign conv = (divsr == '0) ? 64'd0 : mqtr_pkg::sat64(neg, acc);
  assign wdata = {conv, handle_r};

  // head comparison during a scan
  assign p = rdata[95:32];
  always_comb begin
    take = (count_sel != '0) && (!found || ($signed(p) < $signed(best)));
    if (act_r == mqtr_pkg::ACT_POLL && ($signed(p) > $signed(media))) begin
      take = 1'b0;
    end
  end

  assign trk7 = 7'(track_sel);
  assign pick7 = 7'(pick);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    stat.act = act_r;
    stat.drop = trk_oob || (count_sel == DEP_C);
    stat.playing = (play_state == mqtr_pkg::PS_PLAYING);
    stat.clock_ready = clock_ready;
    stat.mul_last = (cnt == ((act_r == mqtr_pkg::ACT_PUSH) ? mqtr_pkg::PUSH_MUL_LAST
                                                           : mqtr_pkg::MEDIA_MUL_LAST));
    stat.div_last = (cnt == mqtr_pkg::DIV_LAST);
    stat.scan_last = (scan_t == LAST_T);
    stat.found = found;
    stat.out_free = out_free;
  end

  mqtr_ram #(
    .W(96),
    .D(ND)
  ) u_entries (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gnum <= mqtr_pkg::GNUM_RST;
      gden <= mqtr_pkg::GDEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        mqtr_pkg::CFG_GNUM: gnum <= cfg_data;
        mqtr_pkg::CFG_GDEN: gden <= cfg_data;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      trk_r <= trk7[TW-1:0];
      trk_oob <= trk7 >= 7'(NUM_TRACKS);
      handle_r <= frame_handle;
      pts_r <= pts;
      num_r <= tb_num;
      den_r <= tb_den;
      now_r <= now_us;
      rate_r <= rate_value;
    end
  end

  // multiply and divide unit
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scale <= prod;
    end
    if (cmd.divsr) begin
      divsr <= prod;
      acc <= '0;
      mcand <= 128'(pts_mag);
      mplier <= 64'(scale);
      cnt <= '0;
      neg <= pts_r[63];
    end
    if (cmd.minit) begin
      acc <= '0;
      mcand <= 128'(delta_mag);
      mplier <= 64'(rate_q16);
      cnt <= '0;
      neg <= delta[63];
    end
    if (cmd.mstep) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand <= {mcand[126:0], 1'b0};
      mplier <= {1'b0, mplier[63:1]};
      cnt <= cnt + 1'b1;
    end
    if (cmd.dinit) begin
      rem <= '0;
      cnt <= '0;
    end
    if (cmd.dstep) begin
      rem <= ge ? r2 - {2'b00, divsr} : r2;
      acc <= {acc[126:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (cmd.combine) begin
      media <= mqtr_pkg::sat64(sum_neg, {16'd0, sum[127:16]});
    end
  end

  // head scan
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.sinit) begin
      found <= 1'b0;
    end else if (cmd.scmp && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sinit) begin
      scan_t <= '0;
    end else if (cmd.scmp) begin
      scan_t <= scan_t + 1'b1;
    end
    if (cmd.scmp && take) begin
      best <= p;
      best_handle <= rdata[31:0];
      pick <= scan_t;
    end
  end

  // playback state and queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      play_state <= mqtr_pkg::PS_STOPPED;
      clock_ready <= 1'b0;
      start_wall <= '0;
      start_media <= '0;
      rate_q16 <= mqtr_pkg::RATE_ONE;
      for (int i = 0; i < NUM_TRACKS; i++) begin
        qhead[i] <= '0;
        qcount[i] <= '0;
      end
    end else begin
      if (cmd.play) begin
        play_state <= mqtr_pkg::PS_PLAYING;
      end
      if (cmd.latch) begin
        start_wall <= now_r;
        start_media <= found ? best : 64'd0;
        clock_ready <= 1'b1;
      end
      if (cmd.wr) begin
        qcount[qidx] <= count_sel + 1'b1;
      end
      if (cmd.pop) begin
        qhead[qidx] <= head_inc;
        qcount[qidx] <= count_sel - 1'b1;
      end
      if (cmd.misc) begin
        case (act_r)
          mqtr_pkg::ACT_PAUSE: play_state <= mqtr_pkg::PS_PAUSED;
          mqtr_pkg::ACT_STOP:  play_state <= mqtr_pkg::PS_STOPPED;
          mqtr_pkg::ACT_RESET: begin
            play_state <= mqtr_pkg::PS_STOPPED;
            clock_ready <= 1'b0;
            start_wall <= '0;
            start_media <= '0;
            rate_q16 <= mqtr_pkg::RATE_ONE;
            for (int i = 0; i < NUM_TRACKS; i++) begin
              qhead[i] <= '0;
              qcount[i] <= '0;
            end
          end
          mqtr_pkg::ACT_RATE: begin
            if (rate_r != '0) begin
              rate_q16 <= rate_r;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= mqtr_pkg::RES_NONE;
      res_track <= '0;
      res_handle <= '0;
      res_pts <= '0;
      res_send <= '0;
    end
    if (cmd.drop) begin
      res_status <= mqtr_pkg::RES_DROP;
    end
    if (cmd.pop) begin
      res_status <= mqtr_pkg::RES_FRAME;
      res_track <= pick7[2:0];
      res_handle <= best_handle;
      res_pts <= best;
      res_send <= now_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status <= res_status;
      track_out <= res_track;
      handle_out <= res_handle;
      pts_out <= res_pts;
      send_time_out <= res_send;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.wr |-> (count_sel != DEP_C))
    else $error("push written into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> (found && (count_sel != '0)))
    else $error("release from an empty queue");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("result overwrites an untaken item");

  a_latch_play: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (clock_ready && (play_state == mqtr_pkg::PS_PLAYING)))
    else $error("clock latched without playing");

endmodule

FILE: src/multi_queue_timestamp_release.sv
// Earliest-deadline frame release over NUM_TRACKS queues of QUEUE_DEPTH entries each.
// One item is worked at a time; the output register lets the next item enter while the
// previous result waits. A push runs the scale and the divisor on a shared 31x31
// multiplier, then a serial shift-add multiply and a one-bit-a-cycle restoring divide,
// plus accept, decode, divide setup, write and result. A poll while playing runs 32
// serial multiply steps for the media time, then reads each queue head from the entry
// memory track by track; a first play scans the heads the same way, and any other play,
// a poll while not playing, pause, stop, reset, set rate and a dropped push go through
// accept, decode and result only. A stalled result holds back the item behind it in its
// result step. The entry memory needs no clearing pass.
module multi_queue_timestamp_release #(
  parameter int NUM_TRACKS  = 8,
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          action,
  input  logic [2:0]          track_sel,
  input  logic [31:0]         frame_handle,
  input  logic signed [63:0]  pts,
  input  logic [30:0]         tb_num,
  input  logic [30:0]         tb_den,
  input  logic [62:0]         now_us,
  input  logic [31:0]         rate_value,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [30:0]         cfg_data,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          status,
  output logic [2:0]          track_out,
  output logic [31:0]         handle_out,
  output logic signed [63:0]  pts_out,
  output logic [62:0]         send_time_out
);

  mqtr_pkg::cmd_t  cmd;
  mqtr_pkg::stat_t stat;

  // sequencer
  mqtr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat    (stat),
    .cmd     (cmd)
  );

  // queues, arithmetic and result register
  mqtr_dp #(
    .NUM_TRACKS (NUM_TRACKS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .track_sel    (track_sel),
    .frame_handle (frame_handle),
    .pts          (pts),
    .tb_num       (tb_num),
    .tb_den       (tb_den),
    .now_us       (now_us),
    .rate_value   (rate_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .track_out    (track_out),
    .handle_out   (handle_out),
    .pts_out      (pts_out),
    .send_time_out(send_time_out)
  );

endmodule

FILE: sim/multi_queue_timestamp_release_tb.sv
`timescale 1ns / 100ps

module multi_queue_timestamp_release_tb;

  localparam int TRACKS = 8;
  localparam int DEPTH  = 16;
  localparam int STALL_LIMIT = 20000;
  localparam logic signed [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam mqtr_pkg::act_t ACT_UNUSED = 3'd7;

  typedef struct {
    mqtr_pkg::act_t     action;
    logic [2:0]         track;
    logic [31:0]        handle;
    logic signed [63:0] pts;
    logic [30:0]        num;
    logic [30:0]        den;
    logic [62:0]        now;
    logic [31:0]        rate;
  } frame_cmd_t;

  typedef struct {
    mqtr_pkg::res_t     status;
    logic [2:0]         track;
    logic [31:0]        handle;
    logic signed [63:0] pts;
    logic [62:0]        send_time;
  } release_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] action = '0;
  logic [2:0] track_sel = '0;
  logic [31:0] frame_handle = '0;
  logic signed [63:0] pts = '0;
  logic [30:0] tb_num = '0;
  logic [30:0] tb_den = '0;
  logic [62:0] now_us = '0;
  logic [31:0] rate_value = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [0:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [1:0] status;
  logic [2:0] track_out;
  logic [31:0] handle_out;
  logic signed [63:0] pts_out;
  logic [62:0] send_time_out;

  multi_queue_timestamp_release #(
    .NUM_TRACKS(TRACKS),
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .track_sel(track_sel), .frame_handle(frame_handle), .pts(pts),
    .tb_num(tb_num), .tb_den(tb_den), .now_us(now_us), .rate_value(rate_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .track_out(track_out), .handle_out(handle_out),
    .pts_out(pts_out), .send_time_out(send_time_out)
  );

  always #5 clk = ~clk;

  // scheduler model state
  logic [30:0]        g_num, g_den;
  mqtr_pkg::play_t    sched_state;
  bit                 clk_latched;
  logic [63:0]        wall_origin;
  logic signed [63:0] media_origin;
  logic [31:0]        play_rate;
  logic signed [63:0] slot_pts [TRACKS*DEPTH];
  logic [31:0]        slot_handle [TRACKS*DEPTH];
  int                 q_head [TRACKS];
  int                 q_count [TRACKS];

  frame_cmd_t pending_cmds [$];
  release_t   due_releases [$];
  int  err_count = 0;
  int  in_gap = 0;
  int  out_gap = 0;
  bit  no_idle = 1'b0;
  int  idle_cycles = 0;

  function automatic logic signed [63:0] clamp_s64(bit neg, logic [127:0] m);
    if (!neg) return (m > 128'(S64_MAX)) ? S64_MAX : m[63:0];
    return (m >= (128'd1 << 63)) ? S64_MIN : 64'd0 - m[63:0];
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] v);
    return v < 0 ? 64'd0 - v : v;
  endfunction

  function automatic logic signed [63:0] to_global(logic signed [63:0] ts,
                                                   logic [30:0] n, logic [30:0] d);
    logic [127:0] prod, dv;
    if (d == 0 || g_num == 0) return 64'sd0;
    prod = 128'(abs64(ts)) * (128'(n) * 128'(g_den));
    dv = 128'(d) * 128'(g_num);
    return clamp_s64(ts < 0, prod / dv);
  endfunction

  function automatic logic signed [63:0] media_now(logic [62:0] nw);
    logic signed [63:0] delta;
    logic [127:0] a, b, sum;
    bit na, nb, ns;
    delta = {1'b0, nw} - wall_origin;
    na = media_origin < 0;
    nb = delta < 0;
    a = 128'(abs64(media_origin)) << 16;
    b = 128'(abs64(delta)) * 128'(play_rate);
    if (na == nb) begin
      sum = a + b;
      ns = na;
    end else if (a >= b) begin
      sum = a - b;
      ns = na;
    end else begin
      sum = b - a;
      ns = nb;
    end
    return clamp_s64(ns, sum >> 16);
  endfunction

  function automatic int head_slot(int t);
    return t * DEPTH + q_head[t];
  endfunction

  function automatic void clear_sched();
    sched_state = mqtr_pkg::PS_STOPPED;
    clk_latched = 0;
    wall_origin = '0;
    media_origin = '0;
    play_rate = mqtr_pkg::RATE_ONE;
    for (int t = 0; t < TRACKS; t++) begin
      q_head[t] = 0;
      q_count[t] = 0;
    end
  endfunction

  // append one item to the pending list
  function automatic void enqueue_cmd(frame_cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  // work out the result of one accepted item
  function automatic release_t schedule_item(frame_cmd_t c);
    release_t r;
    bit found;
    logic signed [63:0] best, media;
    int pick, s;
    r = '{mqtr_pkg::RES_NONE, '0, '0, '0, '0};
    found = 0;
    best = '0;
    pick = 0;
    case (c.action)
      mqtr_pkg::ACT_PUSH: begin
        if (q_count[c.track] >= DEPTH) begin
          r.status = mqtr_pkg::RES_DROP;
        end else begin
          s = c.track * DEPTH + (q_head[c.track] + q_count[c.track]) % DEPTH;
          slot_pts[s] = to_global(c.pts, c.num, c.den);
          slot_handle[s] = c.handle;
          q_count[c.track]++;
        end
      end
      mqtr_pkg::ACT_PLAY: begin
        if (sched_state != mqtr_pkg::PS_PLAYING) begin
          sched_state = mqtr_pkg::PS_PLAYING;
          if (!clk_latched) begin
            for (int t = 0; t < TRACKS; t++) begin
              if (q_count[t] != 0 && (!found || slot_pts[head_slot(t)] < best)) begin
                best = slot_pts[head_slot(t)];
                found = 1;
              end
            end
            wall_origin = {1'b0, c.now};
            media_origin = best;
            clk_latched = 1;
          end
        end
      end
      mqtr_pkg::ACT_PAUSE: sched_state = mqtr_pkg::PS_PAUSED;
      mqtr_pkg::ACT_STOP:  sched_state = mqtr_pkg::PS_STOPPED;
      mqtr_pkg::ACT_RESET: clear_sched();
      mqtr_pkg::ACT_POLL: begin
        if (sched_state == mqtr_pkg::PS_PLAYING && clk_latched) begin
          media = media_now(c.now);
          for (int t = 0; t < TRACKS; t++) begin
            if (q_count[t] != 0 && slot_pts[head_slot(t)] <= media &&
                (!found || slot_pts[head_slot(t)] < best)) begin
              found = 1;
              best = slot_pts[head_slot(t)];
              pick = t;
            end
          end
          if (found) begin
            r.status = mqtr_pkg::RES_FRAME;
            r.track = pick[2:0];
            r.handle = slot_handle[head_slot(pick)];
            r.pts = best;
            r.send_time = c.now;
            q_head[pick] = (q_head[pick] + 1) % DEPTH;
            q_count[pick]--;
          end
        end
      end
      mqtr_pkg::ACT_RATE: if (c.rate != 0) play_rate = c.rate;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        due_releases.insert(due_releases.size(), schedule_item(pending_cmds[0]));
        pending_cmds.delete(0);
      end
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_cmds.size() > 0 && (no_idle || $urandom_range(0, 7) != 0)) begin
        in_valid <= 1'b1;
        action <= pending_cmds[0].action;
        track_sel <= pending_cmds[0].track;
        frame_handle <= pending_cmds[0].handle;
        pts <= pending_cmds[0].pts;
        tb_num <= pending_cmds[0].num;
        tb_den <= pending_cmds[0].den;
        now_us <= pending_cmds[0].now;
        rate_value <= pending_cmds[0].rate;
      end else begin
        in_valid <= 1'b0;
        if (pending_cmds.size() > 0) in_gap <= $urandom_range(0, 9);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    release_t w;
    if (rst) begin
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) begin
        if (due_releases.size() == 0) begin
          report_mismatch("unexpected result, status", status, 0);
        end else begin
          w = due_releases[0];
          due_releases.delete(0);
          if (status !== w.status) report_mismatch("status", status, w.status);
          if (track_out !== w.track) report_mismatch("track_out", track_out, w.track);
          if (handle_out !== w.handle) report_mismatch("handle_out", handle_out, w.handle);
          if (pts_out !== w.pts) report_mismatch("pts_out", pts_out, w.pts);
          if (send_time_out !== w.send_time)
            report_mismatch("send_time_out", send_time_out, w.send_time);
        end
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_gap <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus helpers
  logic [62:0] wall;
  logic signed [63:0] pts_base;

  function automatic frame_cmd_t mk(mqtr_pkg::act_t a, logic [2:0] t,
                                    logic signed [63:0] p,
                                    logic [30:0] n, logic [30:0] d, logic [62:0] nw,
                                    logic [31:0] rt);
    frame_cmd_t c;
    c.action = a;
    c.track = t;
    c.handle = $urandom;
    c.pts = p;
    c.num = n;
    c.den = d;
    c.now = nw;
    c.rate = rt;
    return c;
  endfunction

  function automatic frame_cmd_t noise_cmd();
    frame_cmd_t c;
    c.action = $urandom_range(0, 7);
    c.track = $urandom;
    c.handle = $urandom;
    c.pts = {$urandom, $urandom};
    c.num = $urandom;
    c.den = $urandom;
    c.now = {$urandom, $urandom};
    c.rate = $urandom;
    return c;
  endfunction

  task automatic add_random(int n);
    int r;
    frame_cmd_t c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      wall += $urandom_range(0, 40000);
      pts_base += $urandom_range(0, 2000);
      if (r < 45) begin
        c = mk(mqtr_pkg::ACT_PUSH, $urandom, pts_base + $urandom_range(0, 4000), 1,
               ($urandom_range(0, 1) != 0) ? 31'd90000 : 31'd1000, wall, $urandom);
        if ($urandom_range(0, 9) == 0)
          c = mk(mqtr_pkg::ACT_PUSH, $urandom, {$urandom, $urandom},
                 $urandom, $urandom, wall, $urandom);
      end else if (r < 75) c = mk(mqtr_pkg::ACT_POLL, $urandom, '0, '0, '0, wall, $urandom);
      else if (r < 80) c = mk(mqtr_pkg::ACT_PLAY, $urandom, '0, '0, '0, wall, $urandom);
      else if (r < 83) c = mk(mqtr_pkg::ACT_PAUSE, $urandom, '0, '0, '0, wall, $urandom);
      else if (r < 86) c = mk(mqtr_pkg::ACT_STOP, $urandom, '0, '0, '0, wall, $urandom);
      else if (r < 88) c = mk(mqtr_pkg::ACT_RESET, $urandom, '0, '0, '0, wall, $urandom);
      else if (r < 93) c = mk(mqtr_pkg::ACT_RATE, $urandom, '0, '0, '0, wall,
                              ($urandom_range(0, 3) == 0) ? 32'd0 :
                              ($urandom_range(0, 1) != 0) ? mqtr_pkg::RATE_ONE :
                              32'($urandom_range(8192, 262144)));
      else c = noise_cmd();
      enqueue_cmd(c);
    end
  endtask

  task automatic write_reg(mqtr_pkg::cfg_idx_t idx, logic [30:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == mqtr_pkg::CFG_GNUM) g_num = val;
    else g_den = val;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || due_releases.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  logic [30:0] num_set [6] = '{31'd1, 31'd0, 31'h7FFF_FFFF, 31'd1, 31'd3, 31'd1};
  logic [30:0] den_set [6] = '{31'd1000000, 31'd5, 31'h7FFF_FFFF, 31'd0, 31'd1000,
                               31'd1000000};

  initial begin
    g_num = mqtr_pkg::GNUM_RST;
    g_den = mqtr_pkg::GDEN_RST;
    clear_sched();
    wall = 63'd1000;
    pts_base = 64'sd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every action, full queue, zero denominators
    enqueue_cmd(mk(mqtr_pkg::ACT_POLL, 0, 0, 0, 0, 63'd5, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PUSH, 3'd0, S64_MAX, 31'h7FFF_FFFF, 31'd1, 0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PUSH, 3'd1, S64_MIN, 31'h7FFF_FFFF, 31'd1, 0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PUSH, 3'd2, -64'sd12345, 31'd1, 31'd0, 0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PUSH, 3'd7, 64'sd90000, 31'd1, 31'd90000, 0, 0));
    for (int i = 0; i < DEPTH + 1; i++)
      enqueue_cmd(mk(mqtr_pkg::ACT_PUSH, 3'd4, 64'(i), 31'd1, 31'd1000, 0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PLAY, 0, 0, 0, 0, 63'd100, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PLAY, 0, 0, 0, 0, 63'd200, 0));
    for (int i = 0; i < 4; i++)
      enqueue_cmd(mk(mqtr_pkg::ACT_POLL, 0, 0, 0, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_RATE, 0, 0, 0, 0, 0, 32'd0));
    enqueue_cmd(mk(mqtr_pkg::ACT_RATE, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    enqueue_cmd(mk(mqtr_pkg::ACT_POLL, 0, 0, 0, 0, 63'd0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PAUSE, 0, 0, 0, 0, 0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_POLL, 0, 0, 0, 0, 63'd300, 0));
    enqueue_cmd(mk(ACT_UNUSED, 3'd7, -1, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                   63'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF));
    enqueue_cmd(mk(mqtr_pkg::ACT_STOP, 0, 0, 0, 0, 0, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_PLAY, 0, 0, 0, 0, 63'd400, 0));
    enqueue_cmd(mk(mqtr_pkg::ACT_RESET, 0, 0, 0, 0, 0, 0));
    drain();

    // random phases under several time base settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(mqtr_pkg::CFG_GNUM, num_set[ph]);
      write_reg(mqtr_pkg::CFG_GDEN, den_set[ph]);
      if (ph == 5) no_idle = 1'b1;
      enqueue_cmd(mk(mqtr_pkg::ACT_RESET, 0, 0, 0, 0, 0, 0));
      add_random(105);
      drain();
    end

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
